>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker in tte_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: name");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: name");

`endif

>>> hdl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Types, codes and helpers shared by the terminal engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tte_pkg;

	// Widths that cover the largest supported screen.
	localparam int ROW_W = 6;
	localparam int COL_W = 7;
	localparam int PARAM_W = 16;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESC = 2'd1;
	localparam logic [1:0] MODE_CSI = 2'd2;

	localparam logic [3:0] FORE_RESET = 4'd15;
	localparam logic [3:0] BACK_RESET = 4'd0;

	// Commands handed from the parser to the executor.
	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_PUT,
		CMD_BS,
		CMD_DEL,
		CMD_TAB,
		CMD_CR,
		CMD_LF,
		CMD_SAVE,
		CMD_RESTORE,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_HOME,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] ch;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic has_col;
		logic [PARAM_W-1:0] n;
		logic [3:0] fore;
		logic [3:0] back;
		logic [1:0] mode;
	} cmd_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [3:0] fore;
		logic [3:0] back;
		logic [4:0] row;
		logic [6:0] col;
		logic [1:0] mode;
	} res_t;

	// ANSI color number to VGA color code.
	function automatic logic [3:0] ansi_to_vga(input logic [2:0] a);
		logic [3:0] v;
		case (a)
			3'd0: v = 4'd0;
			3'd1: v = 4'd4;
			3'd2: v = 4'd2;
			3'd3: v = 4'd14;
			3'd4: v = 4'd1;
			3'd5: v = 4'd5;
			3'd6: v = 4'd3;
			default: v = 4'd15;
		endcase
		return v;
	endfunction

	// Applies one SGR parameter to a color pair {fore, back}.
	function automatic logic [7:0] apply_sgr(input logic [7:0] colors,
			input logic [PARAM_W-1:0] p);
		logic [7:0] r;
		logic [PARAM_W-1:0] d;
		logic [PARAM_W-1:0] e;
		r = colors;
		d = p - PARAM_W'(30);
		e = p - PARAM_W'(40);
		if (p >= PARAM_W'(30) && p <= PARAM_W'(37)) begin
			r[7:4] = ansi_to_vga(d[2:0]);
		end else if (p >= PARAM_W'(40) && p <= PARAM_W'(47)) begin
			r[3:0] = ansi_to_vga(e[2:0]);
		end else if (p == PARAM_W'(39)) begin
			r[7:4] = FORE_RESET;
		end else if (p == PARAM_W'(49)) begin
			r[3:0] = BACK_RESET;
		end
		return r;
	endfunction

endpackage

>>> hdl/text_terminal_escape_engine_core.sv
// Each command is executed and then reported by the executor; a scroll adds a pass that moves
// the rows up, and a clear of the screen adds a fill pass over all cells.
// The executor takes a new command only after it has reported the last one.
// Reset: asynchronous; afterwards a clearing pass over all ROWS*COLS cells (2000 by default)
// writes white-on-black spaces and holds full high until it ends.
// ----------------------------------------------------------------------------
// text_terminal_escape_engine_core
// Text terminal with an escape parser in front of a screen executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_terminal_escape_engine_core #(
	parameter int COLS = 80,
	parameter int ROWS = 25,
	parameter int PARAM_SLOTS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic opcode,
	input logic [7:0] data_byte,
	input logic [4:0] read_row,
	input logic [6:0] read_col,
	output logic empty,
	input logic pop,
	output logic [7:0] cell_char,
	output logic [3:0] cell_fore,
	output logic [3:0] cell_back,
	output logic [4:0] cursor_row_out,
	output logic [6:0] cursor_col_out,
	output logic [1:0] parse_mode
);

	import tte_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_out;
	res_t res_in;
	res_t res_out;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	logic res_push;
	logic res_full;
	logic busy_init;
	logic take;

	// An input transfer goes only when the command queue has room and the clearing pass after reset has ended.
	assign full = cmd_full | busy_init;
	assign take = push & ~full;

	tte_front #(.COLS(COLS), .ROWS(ROWS), .PARAM_SLOTS(PARAM_SLOTS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.opcode(opcode),
		.data_byte(data_byte),
		.read_row(read_row),
		.read_col(read_col),
		.cmd(cmd_in)
	);

	tte_fifo #(.WIDTH($bits(cmd_t))) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(take),
		.din(cmd_in),
		.full(cmd_full),
		.pop(cmd_pop),
		.dout(cmd_out),
		.empty(cmd_empty)
	);

	tte_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.res(res_in),
		.res_push(res_push),
		.res_full(res_full),
		.busy_init(busy_init)
	);

	tte_fifo #(.WIDTH($bits(res_t))) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.din(res_in),
		.full(res_full),
		.pop(pop),
		.dout(res_out),
		.empty(empty)
	);

	// Result fields.
	assign cell_char = res_out.ch;
	assign cell_fore = res_out.fore;
	assign cell_back = res_out.back;
	assign cursor_row_out = res_out.row;
	assign cursor_col_out = res_out.col;
	assign parse_mode = res_out.mode;

endmodule

>>> hdl/tte_ram.sv
// ----------------------------------------------------------------------------
// tte_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/tte_fifo.sv
// ----------------------------------------------------------------------------
// tte_fifo
// Two-entry queue that lets producer and consumer stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tte_fifo #(
	parameter int WIDTH = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] din,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] dout,
	output logic empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout = mem_q[rd_q];
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;

	// Pointer and occupancy tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

>>> hdl/tte_front.sv
// ----------------------------------------------------------------------------
// tte_front
// Escape parser: classifies each transfer into one executor command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tte_front #(
	parameter int COLS = 80,
	parameter int ROWS = 25,
	parameter int PARAM_SLOTS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic opcode,
	input logic [7:0] data_byte,
	input logic [4:0] read_row,
	input logic [6:0] read_col,
	output tte_pkg::cmd_t cmd
);

	import tte_pkg::*;

	localparam int IW = $clog2(PARAM_SLOTS + 1);

	logic [1:0] mode_q, mode_d;
	logic [7:0] colors_q, colors_d;
	logic [7:0] pend_q, pend_d;
	logic [PARAM_W-1:0] acc_q, acc_d;
	logic [PARAM_W-1:0] p0_q, p0_d;
	logic [PARAM_W-1:0] p1_q, p1_d;
	logic [IW-1:0] idx_q, idx_d;

	logic [19:0] acc_mul;
	logic [PARAM_W-1:0] acc_sat;
	logic slot_free;
	logic [PARAM_W-1:0] fp0;
	logic [PARAM_W-1:0] fp1;
	logic [7:0] fin_colors;
	logic [PARAM_W-1:0] n_val;
	logic in_range;

	// Decimal accumulation with saturation.
	always_comb begin
		acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 20'(data_byte[3:0]);
		acc_sat = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];
	end

	// Values of the sequence at its final byte.
	always_comb begin
		slot_free = (idx_q < IW'(PARAM_SLOTS));
		fp0 = (slot_free && idx_q == IW'(0)) ? acc_q : p0_q;
		fp1 = (slot_free && idx_q == IW'(1)) ? acc_q : p1_q;
		fin_colors = slot_free ? apply_sgr(pend_q, acc_q) : pend_q;
		n_val = (fp0 == '0) ? PARAM_W'(1) : fp0;
		in_range = ({2'b00, read_row} < 7'(ROWS)) && ({1'b0, read_col} < 8'(COLS));
	end

	// Classification and next parser state.
	always_comb begin
		mode_d = mode_q;
		colors_d = colors_q;
		pend_d = pend_q;
		acc_d = acc_q;
		p0_d = p0_q;
		p1_d = p1_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.kind = CMD_NOP;
		cmd.ch = data_byte;
		if (opcode) begin
			cmd.kind = in_range ? CMD_READ : CMD_NOP;
			cmd.row = ROW_W'(read_row);
			cmd.col = read_col;
		end else begin
			case (mode_q)
				MODE_NORMAL: begin
					case (data_byte)
						CH_ESC: mode_d = MODE_ESC;
						CH_DEL: cmd.kind = CMD_DEL;
						CH_BS: cmd.kind = CMD_BS;
						CH_TAB: cmd.kind = CMD_TAB;
						CH_CR: cmd.kind = CMD_CR;
						CH_LF: cmd.kind = CMD_LF;
						default: begin
							if (data_byte >= CH_SPACE && data_byte < CH_DEL) begin
								cmd.kind = CMD_PUT;
							end
						end
					endcase
				end
				MODE_ESC: begin
					mode_d = MODE_NORMAL;
					if (data_byte == "7") begin
						cmd.kind = CMD_SAVE;
					end else if (data_byte == "8") begin
						cmd.kind = CMD_RESTORE;
					end else if (data_byte == "[") begin
						mode_d = MODE_CSI;
						acc_d = '0;
						p0_d = '0;
						p1_d = '0;
						idx_d = '0;
						pend_d = colors_q;
					end
				end
				default: begin
					if (data_byte >= "0" && data_byte <= "9") begin
						if (slot_free) begin
							acc_d = acc_sat;
						end
					end else if (data_byte == ";" && slot_free) begin
						// A finished parameter is folded into the pending colors.
						if (idx_q == IW'(0)) begin
							p0_d = acc_q;
						end
						if (idx_q == IW'(1)) begin
							p1_d = acc_q;
						end
						pend_d = apply_sgr(pend_q, acc_q);
						acc_d = '0;
						idx_d = idx_q + IW'(1);
					end else begin
						mode_d = MODE_NORMAL;
						case (data_byte)
							"m": colors_d = fin_colors;
							"D": begin
								cmd.kind = CMD_LEFT;
								cmd.n = n_val;
							end
							"C": begin
								cmd.kind = CMD_RIGHT;
								cmd.n = n_val;
							end
							"H", "f": begin
								cmd.kind = CMD_HOME;
								cmd.row = (fp0 >= PARAM_W'(ROWS)) ? ROW_W'(ROWS - 1) :
									ROW_W'(fp0);
								cmd.col = (fp1 >= PARAM_W'(COLS)) ? COL_W'(COLS - 1) :
									COL_W'(fp1);
								cmd.has_col = (idx_q != IW'(0));
							end
							"J": begin
								if (fp0 == PARAM_W'(2)) begin
									cmd.kind = CMD_CLEAR;
								end
							end
							default: ;
						endcase
					end
				end
			endcase
		end
		cmd.mode = mode_d;
		cmd.fore = colors_d[7:4];
		cmd.back = colors_d[3:0];
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			colors_q <= {FORE_RESET, BACK_RESET};
			pend_q <= {FORE_RESET, BACK_RESET};
			acc_q <= '0;
			p0_q <= '0;
			p1_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			colors_q <= colors_d;
			pend_q <= pend_d;
			acc_q <= acc_d;
			p0_q <= p0_d;
			p1_q <= p1_d;
			idx_q <= idx_d;
		end
	end

endmodule

>>> hdl/tte_back.sv
// ----------------------------------------------------------------------------
// tte_back
// Executor: owns the cursor and the screen memory and builds each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tte_back #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input logic clk,
	input logic arst_n,
	input tte_pkg::cmd_t cmd,
	input logic cmd_empty,
	output logic cmd_pop,
	output tte_pkg::res_t res,
	output logic res_push,
	input logic res_full,
	output logic busy_init
);

	import tte_pkg::*;

	localparam int NCELLS = ROWS * COLS;
	localparam int AW = $clog2(NCELLS);
	localparam int CW = $clog2(NCELLS + 1);

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_SCROLL,
		ST_REPORT
	} state_t;

	state_t state_q;
	logic init_q;
	logic [CW-1:0] cnt_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] srow_q;
	logic [COL_W-1:0] scol_q;
	logic [15:0] fill_q;
	logic [1:0] mode_q;
	logic rd_ok_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [15:0] wdata;
	logic re;
	logic [AW-1:0] raddr;
	logic [15:0] rdata;

	logic [AW-1:0] cur_addr;
	logic [AW-1:0] arg_addr;
	logic can_back;
	logic [ROW_W-1:0] prev_row;
	logic [COL_W-1:0] prev_col;
	logic [AW-1:0] prev_addr;
	logic [7:0] tab_col;
	logic last_row;
	logic last_col;
	logic [16:0] right_sum;

	tte_ram #(.WIDTH(16), .DEPTH(NCELLS)) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign busy_init = init_q;

	// Cursor arithmetic.
	always_comb begin
		cur_addr = AW'(AW'(row_q) * AW'(COLS) + AW'(col_q));
		arg_addr = AW'(AW'(cmd.row) * AW'(COLS) + AW'(cmd.col));
		can_back = (col_q != '0) || (row_q != '0);
		prev_row = (col_q != '0) ? row_q : row_q - ROW_W'(1);
		prev_col = (col_q != '0) ? col_q - COL_W'(1) : COL_W'(COLS - 1);
		prev_addr = AW'(AW'(prev_row) * AW'(COLS) + AW'(prev_col));
		tab_col = {1'b0, col_q[COL_W-1:3], 3'b000} + 8'd8;
		last_row = (row_q == ROW_W'(ROWS - 1));
		last_col = (col_q == COL_W'(COLS - 1));
		right_sum = 17'(col_q) + 17'(cmd.n);
	end

	// Memory port control per state.
	always_comb begin
		we = 1'b0;
		waddr = cur_addr;
		wdata = {cmd.back, cmd.fore, cmd.ch};
		re = 1'b0;
		raddr = arg_addr;
		cmd_pop = 1'b0;
		case (state_q)
			ST_FILL: begin
				we = 1'b1;
				waddr = AW'(cnt_q);
				wdata = fill_q;
			end
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (cmd.kind == CMD_PUT) begin
						we = 1'b1;
					end
					if (cmd.kind == CMD_DEL && can_back) begin
						we = 1'b1;
						waddr = prev_addr;
						wdata = {cmd.back, cmd.fore, CH_SPACE};
					end
					if (cmd.kind == CMD_READ) begin
						re = 1'b1;
					end
				end
			end
			ST_SCROLL: begin
				// Row below is read the cycle before its write one row up.
				re = (cnt_q < CW'(NCELLS - COLS));
				raddr = AW'(cnt_q + CW'(COLS));
				we = (cnt_q != '0);
				waddr = AW'(cnt_q - CW'(1));
				wdata = (cnt_q <= CW'(NCELLS - COLS)) ? rdata : fill_q;
			end
			default: ;
		endcase
	end

	// Result fields.
	always_comb begin
		res.ch = rd_ok_q ? rdata[7:0] : 8'd0;
		res.fore = rd_ok_q ? rdata[11:8] : 4'd0;
		res.back = rd_ok_q ? rdata[15:12] : 4'd0;
		res.row = row_q[4:0];
		res.col = col_q;
		res.mode = mode_q;
		res_push = (state_q == ST_REPORT) && !res_full;
	end

	// Executor state machine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			init_q <= 1'b1;
			cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
			srow_q <= '0;
			scol_q <= '0;
			fill_q <= {BACK_RESET, FORE_RESET, CH_SPACE};
			mode_q <= MODE_NORMAL;
			rd_ok_q <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NCELLS - 1)) begin
						init_q <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_REPORT;
					end
				end
				ST_IDLE: begin
					if (!cmd_empty) begin
						mode_q <= cmd.mode;
						rd_ok_q <= (cmd.kind == CMD_READ);
						fill_q <= {cmd.back, cmd.fore, CH_SPACE};
						cnt_q <= '0;
						state_q <= ST_REPORT;
						case (cmd.kind)
							CMD_PUT: begin
								if (last_col) begin
									col_q <= '0;
									if (last_row) begin
										state_q <= ST_SCROLL;
									end else begin
										row_q <= row_q + ROW_W'(1);
									end
								end else begin
									col_q <= col_q + COL_W'(1);
								end
							end
							CMD_BS, CMD_DEL: begin
								if (can_back) begin
									row_q <= prev_row;
									col_q <= prev_col;
								end
							end
							CMD_TAB: begin
								if (tab_col >= 8'(COLS)) begin
									col_q <= '0;
									if (last_row) begin
										state_q <= ST_SCROLL;
									end else begin
										row_q <= row_q + ROW_W'(1);
									end
								end else begin
									col_q <= tab_col[COL_W-1:0];
								end
							end
							CMD_CR: col_q <= '0;
							CMD_LF: begin
								if (last_row) begin
									state_q <= ST_SCROLL;
								end else begin
									row_q <= row_q + ROW_W'(1);
								end
							end
							CMD_SAVE: begin
								srow_q <= row_q;
								scol_q <= col_q;
							end
							CMD_RESTORE: begin
								row_q <= srow_q;
								col_q <= scol_q;
							end
							CMD_LEFT: begin
								col_q <= (cmd.n >= 16'(col_q)) ? '0 : col_q - cmd.n[COL_W-1:0];
							end
							CMD_RIGHT: begin
								col_q <= (right_sum >= 17'(COLS)) ? COL_W'(COLS - 1) :
									right_sum[COL_W-1:0];
							end
							CMD_HOME: begin
								row_q <= cmd.row;
								if (cmd.has_col) begin
									col_q <= cmd.col;
								end
							end
							CMD_CLEAR: begin
								row_q <= '0;
								col_q <= '0;
								state_q <= ST_FILL;
							end
							default: ;
						endcase
					end
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NCELLS)) begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/tte_checker.sv
// ----------------------------------------------------------------------------
// tte_checker
// Port-level checks of the terminal engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tte_checker #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input logic [7:0] cell_char,
	input logic [3:0] cell_fore,
	input logic [3:0] cell_back,
	input logic [4:0] cursor_row_out,
	input logic [6:0] cursor_col_out,
	input logic [1:0] parse_mode
);

	// Handshake signals are always driven to known levels outside reset.
	`ASSERT_ALWAYS(a_handshake_known, clk, arst_n, !$isunknown({push, full, pop, empty}))
	// A shown result reports a legal parser mode and an on-screen cursor.
	`ASSERT_ALWAYS(a_mode_legal, clk, arst_n, empty || parse_mode != 2'd3)
	`ASSERT_ALWAYS(a_cursor_on_screen, clk, arst_n, empty || (32'(cursor_row_out) < ROWS && 32'(cursor_col_out) < COLS))
	// A waiting result that is not taken stays as it is.
	`ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable({cell_char, cell_fore, cell_back, cursor_row_out, cursor_col_out, parse_mode}))

endmodule

bind text_terminal_escape_engine_core tte_checker #(.COLS(COLS), .ROWS(ROWS)) u_tte_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.empty(empty),
	.pop(pop),
	.cell_char(cell_char),
	.cell_fore(cell_fore),
	.cell_back(cell_back),
	.cursor_row_out(cursor_row_out),
	.cursor_col_out(cursor_col_out),
	.parse_mode(parse_mode)
);
